@@ rtl/gnss_lock_detector_macros.svh @@
// assertion macros used by the lock detector controller
// expects clk and an active-low rst_n in the scope of use
`ifndef GNSS_LOCK_DETECTOR_MACROS_SVH
`define GNSS_LOCK_DETECTOR_MACROS_SVH

// same-cycle implication, checked out of reset
`define GLD_ASSERT_IMP(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked out of reset
`define GLD_ASSERT_NXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

@@ rtl/gld_pkg.sv @@
// shared types and constants of the gnss lock detector
// used by gld_ctrl, gld_datapath and gnss_lock_detector; no dependencies
package gld_pkg;

  // field and register widths
  localparam int COEF_W      = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int COUNT_W     = 17;
  localparam int SCALE_SHIFT = 8;
  localparam int OUT_DATA_W  = 24;

  // counter saturation value
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h10000;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_COEF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIGNAL_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_THR = 2'd2;

  // configuration reset values
  localparam logic [CFG_W-1:0] FILTER_COEF_RST = 16'd6554;
  localparam logic [CFG_W-1:0] SIGNAL_SCALE_RST = 16'd256;
  localparam logic [CFG_W-1:0] COUNT_THR_RST = 16'd0;

  // shared multiplier operand selection
  typedef logic [1:0] mul_sel_t;
  localparam mul_sel_t MUL_SIG = 2'd0;
  localparam mul_sel_t MUL_NOI = 2'd1;
  localparam mul_sel_t MUL_SCL = 2'd2;

  // commands from controller to datapath
  typedef struct packed {
    logic     load;
    mul_sel_t mul_sel;
    logic     upd_sig;
    logic     upd_noi;
    logic     upd_cnt;
  } gld_cmd_t;

endpackage

@@ rtl/gld_datapath.sv @@
// datapath of the lock detector: config registers, two low-pass filters,
// one shared multiplier and the lock counter; depends on gld_pkg
module gld_datapath import gld_pkg::*; #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  gld_cmd_t                       cmd,
  input  logic signed [SAMPLE_WIDTH-1:0] signal_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] noise_sample,
  input  logic                           cfg_we,
  input  logic [CFG_IDX_W-1:0]           cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  output logic                           locked,
  output logic [COUNT_W-1:0]             lock_count
);

  localparam int W  = SAMPLE_WIDTH + FRACTION_BITS;
  localparam int DW = W + 1;
  localparam int PW = DW + COEF_W + 1;
  localparam logic signed [PW-1:0] RND_HALF = PW'(1) << (COEF_W - 1);

  logic [CFG_W-1:0]               fc_r, scale_r, thr_r;
  logic signed [SAMPLE_WIDTH-1:0] sig_smp_r, noi_smp_r;
  logic signed [W-1:0]            sig_y_r, noi_y_r;
  logic signed [W-1:0]            sig_x, noi_x;
  logic signed [DW-1:0]           diff_s, diff_n, mul_a;
  logic signed [COEF_W:0]         mul_b;
  logic signed [PW-1:0]           prod_c, prod_r, rnd_sum, rnd_shift, noi_cmp;
  logic signed [W-1:0]            delta;
  logic                           above;
  logic                           lock_r, lock_nxt;
  logic [COUNT_W-1:0]             cnt_r, cnt_nxt;

  // configuration registers, out-of-range indexes ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fc_r    <= FILTER_COEF_RST;
      scale_r <= SIGNAL_SCALE_RST;
      thr_r   <= COUNT_THR_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FILTER_COEF:  fc_r <= cfg_data;
        REG_SIGNAL_SCALE: scale_r <= cfg_data;
        REG_COUNT_THR:    thr_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sample capture on input transfer
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sig_smp_r <= signal_sample;
      noi_smp_r <= noise_sample;
    end
  end

  // samples in filter format and filter errors
  assign sig_x  = $signed({sig_smp_r, {FRACTION_BITS{1'b0}}});
  assign noi_x  = $signed({noi_smp_r, {FRACTION_BITS{1'b0}}});
  assign diff_s = $signed({sig_x[W-1], sig_x}) - $signed({sig_y_r[W-1], sig_y_r});
  assign diff_n = $signed({noi_x[W-1], noi_x}) - $signed({noi_y_r[W-1], noi_y_r});

  // shared multiplier operands
  always_comb begin
    case (cmd.mul_sel)
      MUL_SIG: mul_a = diff_s;
      MUL_NOI: mul_a = diff_n;
      MUL_SCL: mul_a = $signed({sig_y_r[W-1], sig_y_r});
      default: mul_a = diff_s;
    endcase
  end
  assign mul_b  = (cmd.mul_sel == MUL_SCL) ? $signed({1'b0, scale_r}) : $signed({1'b0, fc_r});
  assign prod_c = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod_r <= prod_c;
  end

  // round half up back to filter format
  assign rnd_sum   = prod_r + RND_HALF;
  assign rnd_shift = rnd_sum >>> COEF_W;
  assign delta     = rnd_shift[W-1:0];

  // filter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sig_y_r <= '0;
      noi_y_r <= '0;
    end else begin
      if (cmd.upd_sig) sig_y_r <= sig_y_r + delta;
      if (cmd.upd_noi) noi_y_r <= noi_y_r + delta;
    end
  end

  // scaled signal against noise, both with scale fraction bits
  assign noi_cmp = $signed({{(PW-W-SCALE_SHIFT){noi_y_r[W-1]}}, noi_y_r,
                            {SCALE_SHIFT{1'b0}}});
  assign above   = prod_r > noi_cmp;

  // lock counter and flag
  always_comb begin
    lock_nxt = lock_r;
    cnt_nxt  = cnt_r;
    if (above) begin
      if (cnt_r > {1'b0, thr_r}) begin
        lock_nxt = 1'b1;
      end else if (cnt_r != COUNT_MAX) begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end else begin
      lock_nxt = 1'b0;
      cnt_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lock_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.upd_cnt) begin
      lock_r <= lock_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // lock state doubles as the output holding register
  assign locked     = lock_r;
  assign lock_count = cnt_r;

endmodule

@@ rtl/gld_ctrl.sv @@
// controller of the lock detector: sequences the shared multiplier,
// handles both stream handshakes; depends on gld_pkg and the macro header
`include "gnss_lock_detector_macros.svh"

module gld_ctrl import gld_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output gld_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SIG  = 3'd1;
  localparam logic [2:0] ST_NOI  = 3'd2;
  localparam logic [2:0] ST_SCL  = 3'd3;
  localparam logic [2:0] ST_CMP  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free, in_xfer;

  // result slot is free when empty or being drained this cycle
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) || ((state_r == ST_CMP) && out_free);
  assign in_xfer   = in_tvalid && in_tready;

  // next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    cmd.load      = in_xfer;
    cmd.mul_sel   = MUL_SIG;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) state_nxt = ST_SIG;
      end
      ST_SIG: begin
        cmd.mul_sel = MUL_SIG;
        state_nxt   = ST_NOI;
      end
      ST_NOI: begin
        cmd.mul_sel = MUL_NOI;
        cmd.upd_sig = 1'b1;
        state_nxt   = ST_SCL;
      end
      ST_SCL: begin
        cmd.mul_sel = MUL_SCL;
        cmd.upd_noi = 1'b1;
        state_nxt   = ST_CMP;
      end
      ST_CMP: begin
        // keep the scaled product in place while the result slot is busy
        cmd.mul_sel = MUL_SCL;
        if (out_free) begin
          cmd.upd_cnt   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = in_xfer ? ST_SIG : ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // checks
  `GLD_ASSERT_NXT(a_in_starts_seq, in_tvalid && in_tready, state_r == ST_SIG, "transfer did not start sequence")
  `GLD_ASSERT_NXT(a_sig_to_noi, state_r == ST_SIG, state_r == ST_NOI, "signal step not followed by noise step")
  `GLD_ASSERT_IMP(a_upd_needs_slot, cmd.upd_cnt, out_free, "result overwritten before transfer")
  `GLD_ASSERT_IMP(a_one_update, 1'b1, $onehot0({cmd.upd_sig, cmd.upd_noi, cmd.upd_cnt}), "several updates at once")

endmodule

@@ rtl/gnss_lock_detector.sv @@
// lock detector: each item is sequenced through a single shared
// multiplier (signal filter, noise filter, scale) then the compare and count.
// the result shows on out_tvalid after the signal, noise, scale and compare steps.
// a held result stalls only the compare step; a new input is taken there once the slot is free.
// synchronous active-low reset clears filters, counter, flag and sets the
// registers to their defaults; depends on gld_pkg, gld_ctrl, gld_datapath
module gnss_lock_detector import gld_pkg::*; #(
  parameter int SAMPLE_WIDTH  = 16,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  // signal_sample, noise_sample, zero fill
  input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]       in_tdata,
  input  logic                                      in_tvalid,
  output logic                                      in_tready,
  // locked, lock_count, zero fill
  output logic [OUT_DATA_W-1:0]                     out_tdata,
  output logic                                      out_tvalid,
  input  logic                                      out_tready,
  input  logic                                      cfg_we,
  input  logic [CFG_IDX_W-1:0]                      cfg_index,
  input  logic [CFG_W-1:0]                          cfg_data
);

  gld_cmd_t           cmd;
  logic               locked;
  logic [COUNT_W-1:0] lock_count;

  gld_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  gld_datapath #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .signal_sample ($signed(in_tdata[SAMPLE_WIDTH-1:0])),
    .noise_sample  ($signed(in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH])),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .locked        (locked),
    .lock_count    (lock_count)
  );

  // result packing
  assign out_tdata = {{(OUT_DATA_W-COUNT_W-1){1'b0}}, lock_count, locked};

endmodule

@@ dv/tb.sv @@
// testbench for gnss_lock_detector: streams signal and noise readings with random
// gaps and stalls, predicts filter, compare and lock count in fixed point, checks each result
// depends on gld_pkg and the gnss_lock_detector rtl
module tb;
  import gld_pkg::*;

  localparam int SAMPLE_W      = 16;
  localparam int FRAC_BITS     = 16;
  localparam int IN_DATA_W     = ((2*SAMPLE_W+7)/8)*8;
  localparam int LATENCY       = 4;
  localparam int MAX_GAP       = 12;
  localparam int RUN_LIMIT     = 2_000_000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_ITEMS   = 125;
  localparam int SAT_ITEMS     = 120;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic               locked;
    logic [COUNT_W-1:0] count;
  } lock_status_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  // signal_sample, noise_sample, zero fill
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  // locked, lock_count, zero fill
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_FILTER_COEF;
  logic [CFG_W-1:0] cfg_data = '0;

  // predicted detector state and registers
  longint signal_level = 0;
  longint noise_level = 0;
  logic [COUNT_W-1:0] above_run = '0;
  logic lock_state = 1'b0;
  logic [CFG_W-1:0] coef_q = FILTER_COEF_RST;
  logic [CFG_W-1:0] scale_q = SIGNAL_SCALE_RST;
  logic [CFG_W-1:0] thr_q = COUNT_THR_RST;

  lock_status_t pending_status[$];
  bit idle_on = 1'b1;
  int fail_count = 0;
  int readings_sent = 0;
  int results_seen = 0;
  int locked_seen = 0;
  int cycle_count = 0;
  int rx_wait = 0;

  gnss_lock_detector #(
    .SAMPLE_WIDTH (SAMPLE_W),
    .FRACTION_BITS(FRAC_BITS)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .out_tdata (out_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > RUN_LIMIT) begin
      $display("FAIL gnss_lock_detector");
      $finish;
    end
  end

  // one low-pass update, product rounded half up back to the filter format
  function automatic longint lowpass_step(longint level, logic signed [SAMPLE_W-1:0] reading);
    longint prod;
    prod = longint'(coef_q) * ((longint'(reading) <<< FRAC_BITS) - level);
    return level + ((prod + (longint'(1) <<< (COEF_W - 1))) >>> COEF_W);
  endfunction

  // advance the predicted state by one period and queue the expected status
  function automatic void predict_status(input logic signed [SAMPLE_W-1:0] sig,
                                         input logic signed [SAMPLE_W-1:0] noi);
    signal_level = lowpass_step(signal_level, sig);
    noise_level = lowpass_step(noise_level, noi);
    if (signal_level * longint'(scale_q) > noise_level * (longint'(1) <<< SCALE_SHIFT)) begin
      if (above_run > thr_q) lock_state = 1'b1;
      else if (above_run < COUNT_MAX) above_run = above_run + 1'b1;
    end else begin
      lock_state = 1'b0;
      above_run = '0;
    end
    pending_status.push_back('{locked: lock_state, count: above_run});
  endfunction

  // result side: check each transfer, then draw the stall before the next one
  always @(posedge clk) begin : status_check
    lock_status_t want;
    logic got_locked;
    logic [COUNT_W-1:0] got_count;
    if (rst_n && out_tvalid && out_tready) begin
      got_locked = out_tdata[0];
      got_count = out_tdata[COUNT_W:1];
      results_seen++;
      if (got_locked) locked_seen++;
      if (pending_status.size() == 0) begin
        $error("result with no reading waiting: locked %0d, lock_count %0d",
               got_locked, got_count);
        fail_count++;
      end else begin
        want = pending_status.pop_front();
        if (got_locked !== want.locked) begin
          $error("locked mismatch: expected %0d, actual %0d", want.locked, got_locked);
          fail_count++;
        end
        if (got_count !== want.count) begin
          $error("lock_count mismatch: expected %0d, actual %0d", want.count, got_count);
          fail_count++;
        end
      end
      rx_wait = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
    end
    out_tready <= (rx_wait == 0);
  end

  // one reading transfer after a random gap; valid stays high into the next call
  task automatic send_reading(input logic signed [SAMPLE_W-1:0] sig,
                              input logic signed [SAMPLE_W-1:0] noi);
    int gap;
    gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata <= IN_DATA_W'({noi, sig});
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    predict_status(sig, noi);
    readings_sent++;
  endtask

  // hold off until every expected status is back and the pipeline is empty
  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      REG_FILTER_COEF:  coef_q = value;
      REG_SIGNAL_SCALE: scale_q = value;
      REG_COUNT_THR:    thr_q = value;
      default: ;
    endcase
  endtask

  // program all registers back to back, optionally with a write to the unused index
  task automatic write_registers(input logic [CFG_W-1:0] coef, input logic [CFG_W-1:0] scale,
                                 input logic [CFG_W-1:0] thr, input bit stray);
    wait_for_results();
    write_one(REG_FILTER_COEF, coef);
    write_one(REG_SIGNAL_SCALE, scale);
    write_one(REG_COUNT_THR, thr);
    if (stray) write_one(REG_UNUSED, CFG_W'($urandom));
    cfg_we <= 1'b0;
  endtask

  // identical readings from reset keep both filters equal: never above
  task automatic test_equal_readings();
    send_reading(16'sd0, 16'sd0);
    send_reading(16'sd1000, 16'sd1000);
    send_reading(-16'sd32768, -16'sd32768);
    send_reading(16'sd32767, 16'sd32767);
  endtask

  // full-scale readings with the largest coefficient: lock, then clear
  task automatic test_extreme_readings();
    write_registers(16'hFFFF, SIGNAL_SCALE_RST, 16'd2, 1'b0);
    repeat (4) send_reading(16'sd32767, -16'sd32768);
    repeat (2) send_reading(-16'sd32768, 16'sd32767);
  endtask

  // zero coefficient holds the filters, zero scale zeroes the signal side
  task automatic test_zero_coefficient();
    write_registers(16'd0, 16'd0, 16'd0, 1'b1);
    repeat (3) send_reading(SAMPLE_W'($urandom), SAMPLE_W'($urandom));
  endtask

  // largest scale against a much stronger noise reading
  task automatic test_scale_extremes();
    write_registers(16'd32768, 16'hFFFF, 16'd1, 1'b1);
    repeat (3) send_reading(16'sd100, 16'sd20000);
    send_reading(-16'sd1, -16'sd32768);
    send_reading(16'sd32767, 16'sd32767);
  endtask

  // raised threshold: the count climbs past it, then locks and holds
  task automatic test_count_saturation();
    write_registers(16'hFFFF, SIGNAL_SCALE_RST, 16'd100, 1'b0);
    idle_on = 1'b0;
    repeat (SAT_ITEMS) send_reading(16'sd20000, -16'sd20000);
    repeat (2) send_reading(-16'sd20000, 16'sd20000);
    wait_for_results();
    idle_on = 1'b1;
  endtask

  // random settings per phase; mostly runs of strong or weak signal, some raw noise
  task automatic test_random_traffic();
    logic [CFG_W-1:0] coef;
    logic [CFG_W-1:0] scale;
    logic [CFG_W-1:0] thr;
    logic signed [SAMPLE_W-1:0] sig;
    logic signed [SAMPLE_W-1:0] noi;
    int kind;
    int run_len;
    int sent;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      coef = (p == 1) ? 16'hFFFF : (p == 2) ? 16'd1 : CFG_W'($urandom_range(2000, 65535));
      scale = (p == 3) ? 16'd0 : (p == 4) ? 16'hFFFF : CFG_W'($urandom_range(128, 640));
      thr = (p == 5) ? CFG_W'($urandom) : CFG_W'($urandom_range(0, 24));
      write_registers(coef, scale, thr, p[0]);
      idle_on = (p % 3 != 2);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        kind = $urandom_range(0, 9);
        run_len = $urandom_range(1, 40);
        for (int i = 0; i < run_len && sent < PHASE_ITEMS; i++) begin
          if (kind < 6) begin
            sig = SAMPLE_W'($urandom_range(1000, 32767));
            noi = SAMPLE_W'(-int'($urandom_range(0, 32768)));
          end else if (kind < 8) begin
            sig = SAMPLE_W'(-int'($urandom_range(0, 32768)));
            noi = SAMPLE_W'($urandom_range(1000, 32767));
          end else begin
            sig = SAMPLE_W'($urandom);
            noi = SAMPLE_W'($urandom);
          end
          send_reading(sig, noi);
          sent++;
        end
        // occasional full drain mid-stream
        if ($urandom_range(0, 19) == 0) wait_for_results();
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_equal_readings();
    test_extreme_readings();
    test_zero_coefficient();
    test_scale_extremes();
    test_count_saturation();
    test_random_traffic();
    wait_for_results();
    $display("covered %0d readings and %0d status transfers, %0d of them locked,",
             readings_sent, results_seen, locked_seen);
    $display("over reset, extreme and random register settings including a long climb to lock");
    if (fail_count == 0) begin
      $display("PASS gnss_lock_detector");
    end else begin
      $display("FAIL gnss_lock_detector");
    end
    $finish;
  end

endmodule
